[rtl/core/csc_pkg.sv]
package csc_pkg;

    // Number of rotation steps and width of the internal x, y and z words.
    localparam int ITERATIONS = 28;
    localparam int DATA_WIDTH = 32;

    // Width of the interface angle and results.
    localparam int IO_WIDTH = 32;

    // Width of a step index.
    localparam int SHIFT_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

    // pi/4 with a 62-bit fraction, and the CORDIC gain with a 62-bit fraction.
    localparam logic [63:0] PI_Q60   = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] GAIN_Q62 = 64'd2800459869988536347;

    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef logic signed [IO_WIDTH-1:0]   t_io_word;

    // Working set handed from one pipeline stage to the next.
    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
        logic  neg;
    } t_csc_data;

    // Bitwise long division, used only to build constants.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Round half up while dropping s fraction bits.
    function automatic logic [63:0] urnd(input logic [63:0] val, input int s);
        return (val + (64'd1 << (s - 1))) >> s;
    endfunction

    // atan(2^-i) with a 62-bit fraction, from the alternating power series.
    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        sum = '0;
        if (i == 0) begin
            return PI_Q60;
        end
        for (int k = 0; k < 32; k++) begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0) begin
                term = udiv64(64'd1 << e, 64'(2 * k + 1));
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    function automatic t_word fit_word(input logic [63:0] val);
        return val[DATA_WIDTH-1:0];
    endfunction

    // Angle constants in the residual format and the gain in the x, y format.
    localparam t_word PI_Z      = fit_word(urnd(PI_Q60, 64 - DATA_WIDTH));
    localparam t_word TWO_PI_Z  = fit_word(urnd(PI_Q60, 63 - DATA_WIDTH));
    localparam t_word HALF_PI_Z = fit_word(urnd(PI_Q60, 65 - DATA_WIDTH));
    localparam t_word GAIN_XY   = fit_word(urnd(GAIN_Q62, 64 - DATA_WIDTH));

    function automatic t_word atan_z(input int i);
        return fit_word(urnd(atan_q62(i), 66 - DATA_WIDTH));
    endfunction

    // Output limits, plus and minus one in Q2.30.
    localparam t_io_word ONE_Q30     = t_io_word'(64'sd1 <<< 30);
    localparam t_io_word NEG_ONE_Q30 = t_io_word'(-(64'sd1 <<< 30));

endpackage

[rtl/core/csc_pre.sv]
module csc_pre (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [csc_pkg::IO_WIDTH-1:0] i_angle,
    output logic                        o_valid,
    input  logic                        i_ready,
    output csc_pkg::t_csc_data          o_data
);
    import csc_pkg::*;

    logic      r_a_valid;
    t_word     r_a_z;
    t_word     n_a_z;
    t_word     w_z_in;
    logic      r_b_valid;
    t_csc_data r_b_data;
    t_csc_data n_b_data;
    logic      w_a_ready;
    logic      w_b_ready;

    // Bring the angle into the residual format.
    generate
        if (DATA_WIDTH > IO_WIDTH) begin : g_widen
            assign w_z_in = t_word'({i_angle, {(DATA_WIDTH - IO_WIDTH){1'b0}}});
        end else if (DATA_WIDTH == IO_WIDTH) begin : g_same
            assign w_z_in = i_angle;
        end else begin : g_narrow
            assign w_z_in = i_angle[IO_WIDTH-1 -: DATA_WIDTH];
        end
    endgenerate

    // First stage: one wrap by 2*pi into [-pi, pi].
    always_comb begin
        n_a_z = w_z_in;
        if (w_z_in > PI_Z) begin
            n_a_z = w_z_in - TWO_PI_Z;
        end else if (w_z_in < -PI_Z) begin
            n_a_z = w_z_in + TWO_PI_Z;
        end
    end

    // Second stage: fold by pi into [-pi/2, pi/2] and seed x and y.
    always_comb begin
        n_b_data.x   = GAIN_XY;
        n_b_data.y   = '0;
        n_b_data.z   = r_a_z;
        n_b_data.neg = 1'b0;
        if (r_a_z > HALF_PI_Z) begin
            n_b_data.z   = r_a_z - PI_Z;
            n_b_data.neg = 1'b1;
        end else if (r_a_z < -HALF_PI_Z) begin
            n_b_data.z   = r_a_z + PI_Z;
            n_b_data.neg = 1'b1;
        end
    end

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;
    assign o_valid   = r_b_valid;
    assign o_data    = r_b_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_z <= n_a_z;
        end
        if (w_b_ready && r_a_valid) begin
            r_b_data <= n_b_data;
        end
    end

endmodule

[rtl/core/csc_cell.sv]
module csc_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [csc_pkg::SHIFT_W-1:0] i_shift,
    input  csc_pkg::t_word              i_atan,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  csc_pkg::t_csc_data          i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output csc_pkg::t_csc_data          o_data
);
    import csc_pkg::*;

    logic      r_valid;
    t_csc_data r_data;
    t_csc_data n_data;
    t_word     w_dx;
    t_word     w_dy;

    assign w_dx = i_data.y >>> i_shift;
    assign w_dy = i_data.x >>> i_shift;

    // A residual of exactly zero rotates clockwise.
    always_comb begin
        n_data.neg = i_data.neg;
        if (i_data.z > 0) begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - i_atan;
        end else begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + i_atan;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

[rtl/core/csc_post.sv]
module csc_post (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  csc_pkg::t_csc_data                  i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [csc_pkg::IO_WIDTH-1:0] o_sine,
    output logic signed [csc_pkg::IO_WIDTH-1:0] o_cosine
);
    import csc_pkg::*;

    logic     r_c_valid;
    t_io_word r_c_sine;
    t_io_word r_c_cosine;
    logic     r_c_neg;
    logic     r_d_valid;
    t_io_word r_d_sine;
    t_io_word r_d_cosine;
    t_io_word w_sine;
    t_io_word w_cosine;
    logic     w_c_ready;
    logic     w_d_ready;

    function automatic t_io_word clamp_q30(input t_io_word val);
        if (val > ONE_Q30) begin
            return ONE_Q30;
        end
        if (val < NEG_ONE_Q30) begin
            return NEG_ONE_Q30;
        end
        return val;
    endfunction

    // Scale x and y to Q2.30, rounding half up where bits are dropped.
    generate
        if (DATA_WIDTH > IO_WIDTH) begin : g_round
            localparam int DROP = DATA_WIDTH - IO_WIDTH;
            localparam logic signed [DATA_WIDTH:0] HALF =
                (DATA_WIDTH + 1)'(1) << (DROP - 1);
            logic signed [DATA_WIDTH:0] w_ys;
            logic signed [DATA_WIDTH:0] w_xs;
            assign w_ys     = ({i_data.y[DATA_WIDTH-1], i_data.y} + HALF) >>> DROP;
            assign w_xs     = ({i_data.x[DATA_WIDTH-1], i_data.x} + HALF) >>> DROP;
            assign w_sine   = w_ys[IO_WIDTH-1:0];
            assign w_cosine = w_xs[IO_WIDTH-1:0];
        end else if (DATA_WIDTH == IO_WIDTH) begin : g_same
            assign w_sine   = i_data.y;
            assign w_cosine = i_data.x;
        end else begin : g_widen
            assign w_sine   = {i_data.y, {(IO_WIDTH - DATA_WIDTH){1'b0}}};
            assign w_cosine = {i_data.x, {(IO_WIDTH - DATA_WIDTH){1'b0}}};
        end
    endgenerate

    assign w_d_ready = !r_d_valid || i_ready;
    assign w_c_ready = !r_c_valid || w_d_ready;
    assign o_ready   = w_c_ready;
    assign o_valid   = r_d_valid;
    assign o_sine    = r_d_sine;
    assign o_cosine  = r_d_cosine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_c_ready) begin
                r_c_valid <= i_valid;
            end
            if (w_d_ready) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ready && i_valid) begin
            r_c_sine   <= clamp_q30(w_sine);
            r_c_cosine <= clamp_q30(w_cosine);
            r_c_neg    <= i_data.neg;
        end
        if (w_d_ready && r_c_valid) begin
            r_d_sine   <= r_c_neg ? -r_c_sine : r_c_sine;
            r_d_cosine <= r_c_neg ? -r_c_cosine : r_c_cosine;
        end
    end

endmodule

[rtl/core/cordic_sine_cosine.sv]
// Channel   Direction  Valid    Stall    Payload
// angle     in         i_valid  o_stall  i_angle (signed Q3.28)
// result    out        o_valid  i_stall  o_sine, o_cosine (signed Q2.30)
//
// One request is accepted in every cycle while o_stall is low. Each request passes
// through two range reduction stages, one cell for each CORDIC iteration, and two
// output stages before its result appears. Reset clears only the valid bits of
// the stages; no clearing pass is needed. A stall from downstream holds the
// result in place while stages that hold no request keep filling, so o_stall
// rises only when every stage is occupied.
module cordic_sine_cosine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [csc_pkg::IO_WIDTH-1:0] i_angle,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [csc_pkg::IO_WIDTH-1:0] o_sine,
    output logic signed [csc_pkg::IO_WIDTH-1:0] o_cosine
);
    import csc_pkg::*;

    // Link k joins the stage in front of cell k to cell k. Link ITERATIONS feeds
    // the output stages. Ready travels back along the row, so a request moves
    // up whenever the stage ahead of it is empty or is itself moving.
    logic      w_link_valid [ITERATIONS+1];
    logic      w_link_ready [ITERATIONS+1];
    t_csc_data w_link_data  [ITERATIONS+1];
    logic      w_pre_ready;

    // The range reduction brings the angle into [-pi/2, pi/2] and records
    // whether a shift by pi took place, which flips the sign of both results.
    csc_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (w_pre_ready),
        .i_angle (i_angle),
        .o_valid (w_link_valid[0]),
        .i_ready (w_link_ready[0]),
        .o_data  (w_link_data[0])
    );

    assign o_stall = !w_pre_ready;

    // One rotation cell for each iteration. Each cell receives its shift count
    // and its arctangent constant, so all cells share one design.
    generate
        for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
            localparam t_word ATAN = atan_z(g);
            csc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (SHIFT_W'(g)),
                .i_atan  (ATAN),
                .i_valid (w_link_valid[g]),
                .o_ready (w_link_ready[g]),
                .i_data  (w_link_data[g]),
                .o_valid (w_link_valid[g+1]),
                .i_ready (w_link_ready[g+1]),
                .o_data  (w_link_data[g+1])
            );
        end
    endgenerate

    // The output stages round to Q2.30, clamp to plus or minus one, and then
    // apply the sign flip of the pi fold.
    csc_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_link_valid[ITERATIONS]),
        .o_ready  (w_link_ready[ITERATIONS]),
        .i_data   (w_link_data[ITERATIONS]),
        .o_valid  (o_valid),
        .i_ready  (!i_stall),
        .o_sine   (o_sine),
        .o_cosine (o_cosine)
    );

endmodule

[rtl/core/csc_checker.sv]
module csc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic signed [csc_pkg::IO_WIDTH-1:0] i_angle,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [csc_pkg::IO_WIDTH-1:0] o_sine,
    input logic signed [csc_pkg::IO_WIDTH-1:0] o_cosine
);
    import csc_pkg::*;

    // A held result keeps its value until it is taken.
    a_hold: assert property (@(posedge i_clk)
        i_rst_n && o_valid && i_stall |=> o_valid && $stable(o_sine) && $stable(o_cosine))
        else $error("result changed while stalled");

    // The block pushes back only when the pipeline is full and the output is held.
    a_stall_full: assert property (@(posedge i_clk)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while the pipeline has room");

    a_sine_range: assert property (@(posedge i_clk)
        o_valid |-> (o_sine <= ONE_Q30) && (o_sine >= NEG_ONE_Q30))
        else $error("sine beyond plus or minus one");

    a_cosine_range: assert property (@(posedge i_clk)
        o_valid |-> (o_cosine <= ONE_Q30) && (o_cosine >= NEG_ONE_Q30))
        else $error("cosine beyond plus or minus one");

endmodule

bind cordic_sine_cosine csc_checker u_csc_checker (.*);
